@@ rtl/core/i2cm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and segment tables shared by the register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	// one-hot segment kinds of a bus transaction
	typedef enum logic [7:0] {
		SEG_START = 8'b0000_0001,
		SEG_AW    = 8'b0000_0010,
		SEG_REG   = 8'b0000_0100,
		SEG_DATA  = 8'b0000_1000,
		SEG_AR    = 8'b0001_0000,
		SEG_RBYTE = 8'b0010_0000,
		SEG_NACK  = 8'b0100_0000,
		SEG_STOP  = 8'b1000_0000
	} seg_kind_t;

	localparam int SEG_IDX_W = 3;
	localparam int OFF_W     = 5;

	localparam logic [SEG_IDX_W-1:0] LAST_SEG_WR = 3'd4;
	localparam logic [SEG_IDX_W-1:0] LAST_SEG_RD = 3'd7;

	// offsets inside a segment
	localparam logic [OFF_W-1:0] OFF_ACK     = 5'd16;
	localparam logic [OFF_W-1:0] OFF_RB_LAST = 5'd14;
	localparam logic [OFF_W-1:0] OFF_ZERO    = 5'd0;

	localparam logic [6:0] SLAVE_ADDR_RST = 7'd30;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
		logic       nack_seen;
	} res_t;

	// segment order of a write and of a read transaction
	function automatic seg_kind_t seg_kind(input logic op_read, input logic [SEG_IDX_W-1:0] idx);
		seg_kind_t k;
		k = SEG_STOP;
		if (op_read) begin
			case (idx)
				3'd0: k = SEG_START;
				3'd1: k = SEG_AW;
				3'd2: k = SEG_REG;
				3'd3: k = SEG_START;
				3'd4: k = SEG_AR;
				3'd5: k = SEG_RBYTE;
				3'd6: k = SEG_NACK;
				default: k = SEG_STOP;
			endcase
		end else begin
			case (idx)
				3'd0: k = SEG_START;
				3'd1: k = SEG_AW;
				3'd2: k = SEG_REG;
				3'd3: k = SEG_DATA;
				default: k = SEG_STOP;
			endcase
		end
		return k;
	endfunction

	// offset of the final tick of a segment
	function automatic logic [OFF_W-1:0] seg_last_off(input seg_kind_t k);
		logic [OFF_W-1:0] r;
		case (k)
			SEG_AW, SEG_REG, SEG_DATA, SEG_AR: r = 5'd17;
			SEG_RBYTE:                         r = 5'd15;
			default:                           r = 5'd1;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/i2cm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Transaction state and per-tick bus logic; one tick is processed per advance.
// ----------------------------------------------------------------------------
module i2cm_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  i2cm_pkg::req_t item,
	input  logic [6:0]     slave_addr,
	output i2cm_pkg::res_t result
);
	import i2cm_pkg::*;

	logic                 busy_q;
	logic                 rd_q;
	logic [SEG_IDX_W-1:0] seg_q;
	logic [OFF_W-1:0]     off_q;
	logic [7:0]           shift_q;
	logic [7:0]           lreg_q;
	logic [7:0]           ldata_q;
	logic [7:0]           rbyte_q;
	logic                 nack_q;

	logic                 start;
	logic                 active;
	logic                 op_read;
	logic [SEG_IDX_W-1:0] seg;
	logic [OFF_W-1:0]     off;
	logic [7:0]           lreg;
	logic [7:0]           ldata;
	seg_kind_t            kind;
	logic                 high;
	logic [7:0]           sh;
	logic [7:0]           sh_n;
	logic [7:0]           rbyte_n;
	logic                 nack_n;
	logic                 scl;
	logic                 sda;
	logic                 seg_end;
	logic                 last_seg;
	logic                 done;
	logic                 busy_n;
	logic [SEG_IDX_W-1:0] seg_n;
	logic [OFF_W-1:0]     off_n;

	always_comb begin
		start   = !busy_q && (item.cmd == CMD_WRITE || item.cmd == CMD_READ);
		active  = busy_q || start;
		op_read = start ? (item.cmd == CMD_READ) : rd_q;
		seg     = start ? '0 : seg_q;
		off     = start ? OFF_ZERO : off_q;
		lreg    = start ? item.reg_addr : lreg_q;
		ldata   = start ? item.wr_data : ldata_q;
		nack_n  = start ? 1'b0 : nack_q;
		kind    = seg_kind(op_read, seg);
		high    = !off[0];
		sh      = shift_q;
		sh_n    = shift_q;
		rbyte_n = rbyte_q;
		scl     = 1'b1;
		sda     = 1'b1;
		if (active) begin
			case (kind)
				SEG_START: begin
					sda = (off == OFF_ZERO);
				end
				SEG_STOP: begin
					sda = (off != OFF_ZERO);
				end
				SEG_NACK: begin
					scl = high;
				end
				SEG_RBYTE: begin
					sh   = (off == OFF_ZERO) ? 8'h00 : shift_q;
					sh_n = sh;
					scl  = high;
					if (high) begin
						sh_n = {sh[6:0], item.sda_in};
						if (off == OFF_RB_LAST) begin
							rbyte_n = sh_n;
						end
					end
				end
				default: begin
					// address, register and data bytes, msb first, then ack slot
					if (off == OFF_ZERO) begin
						case (kind)
							SEG_AW:   sh = {slave_addr, 1'b0};
							SEG_REG:  sh = lreg;
							SEG_DATA: sh = ldata;
							default:  sh = {slave_addr, 1'b1};
						endcase
					end
					sh_n = sh;
					scl  = high;
					if (off < OFF_ACK) begin
						sda = sh[7];
						if (!high) begin
							sh_n = {sh[6:0], 1'b0};
						end
					end else if (high && item.sda_in) begin
						nack_n = 1'b1;
					end
				end
			endcase
		end
		seg_end  = (off == seg_last_off(kind));
		last_seg = op_read ? (seg == LAST_SEG_RD) : (seg == LAST_SEG_WR);
		done     = active && last_seg && seg_end;
		busy_n   = active && !done;
		seg_n    = seg_end ? seg + SEG_IDX_W'(1) : seg;
		off_n    = seg_end ? OFF_ZERO : off + OFF_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rd_q    <= 1'b0;
			seg_q   <= '0;
			off_q   <= '0;
			rbyte_q <= 8'h00;
			nack_q  <= 1'b0;
		end else if (adv) begin
			busy_q  <= busy_n;
			rd_q    <= op_read;
			seg_q   <= seg_n;
			off_q   <= off_n;
			rbyte_q <= rbyte_n;
			nack_q  <= nack_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shift_q <= sh_n;
			lreg_q  <= lreg;
			ldata_q <= ldata;
		end
	end

	always_comb begin
		result.scl_level = scl;
		result.sda_level = sda;
		result.busy_res  = active;
		result.done_res  = done;
		result.rd_data   = rbyte_n;
		result.nack_seen = nack_n;
	end

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |=> !busy_q)
		else $error("engine still busy after final tick");

	a_seg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !rd_q |-> seg_q <= LAST_SEG_WR)
		else $error("write transaction past its last segment");

	a_off_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> off_q <= seg_last_off(seg_kind(rd_q, seg_q)))
		else $error("offset beyond segment end");

	a_idle_tick_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !busy_q && (item.cmd == CMD_TICK || item.cmd == CMD_RSVD) |=> !busy_q)
		else $error("transaction started without a request");

endmodule

@@ rtl/core/i2c_master_register_access_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit
// I2C master for single-register write and read, one bus half-period per item.
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  req       req_valid / req_ready / req     in, one bus tick with optional request
//  res       res_valid / res_ready / res     out, bus levels and status for that tick
//  cfg       cfg_we / cfg_wdata              in, 7-bit slave address
//
//  one item per cycle sustained while res is not stalled; a taken item reaches res through
//  the input register, then the result register after the engine logic
//  write transaction spans 58 items, read 78; requests while busy are ignored
//  reset clears engine state, read byte, nack flag; slave address resets to 30
//  a stalled res channel holds the result and back-pressures req one stage later
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  i2cm_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output i2cm_pkg::res_t res,
	input  logic           cfg_we,
	input  logic [6:0]     cfg_wdata
);
	import i2cm_pkg::*;

	req_t       req_s1;
	logic       v_s1;
	res_t       res_q;
	logic       res_valid_q;
	logic [6:0] slave_addr_q;
	res_t       eng_res;
	logic       adv;

	assign adv       = v_s1 && (!res_valid_q || res_ready);
	assign req_ready = !v_s1 || adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			res_valid_q  <= 1'b0;
			slave_addr_q <= SLAVE_ADDR_RST;
		end else begin
			if (req_valid && req_ready) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				slave_addr_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (adv) begin
			res_q <= eng_res;
		end
	end

	i2cm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item       (req_s1),
		.slave_addr (slave_addr_q),
		.result     (eng_res)
	);

endmodule
